// File: hw/rtl/gradient_tensor_products_unit_defines.svh
// ----------------------------------------------------------------------------
// Gradient tensor products unit: assertion macros
// Shared property forms for the concurrent checks of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_TENSOR_PRODUCTS_UNIT_DEFINES_SVH
`define GRADIENT_TENSOR_PRODUCTS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GTP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/gtp_pkg.sv
// ----------------------------------------------------------------------------
// Gradient tensor products package
// Widths, register indexes and the types passed between the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtp_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int MIN_SIZE     = 3;

   localparam logic [CSR_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

   localparam int GRAD_W     = 9;
   localparam int PROD_W     = 2 * GRAD_W;
   localparam int XX_W       = 15;
   localparam int XY_W       = 16;
   localparam int YY_W       = 15;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 11;
   localparam int RSP_DATA_W = 72;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 2);

   typedef struct packed {
      logic                     valid;
      logic signed [GRAD_W-1:0] dx;
      logic signed [GRAD_W-1:0] dy;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic                     last;
   } grad_type;

   typedef struct packed {
      logic [XX_W-1:0]  xx;
      logic [XY_W-1:0]  xy;
      logic [YY_W-1:0]  yy;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } result_type;

endpackage

// File: hw/rtl/gtp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gtp_window.sv
// ----------------------------------------------------------------------------
// Gradient tensor products: neighborhood window
// Size registers, raster counters, the combined two-line store and the
// delay taps; forms the central differences for each interior center.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gradient_tensor_products_unit_defines.svh"

module gtp_window #(
   parameter int MAX_WIDTH  = gtp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gtp_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [gtp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gtp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_accept,
   input  logic [gtp_pkg::PIX_W-1:0]        req_pixel,
   input  logic                             req_frame_start,
   output logic                             busy,
   output gtp_pkg::grad_type                grad
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WV = $clog2(MAX_WIDTH + 1);
   localparam int HV = $clog2(MAX_HEIGHT + 1);
   localparam int PW = gtp_pkg::PIX_W;
   localparam int W_RST = (gtp_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                            : gtp_pkg::WIDTH_RESET;
   localparam int H_RST = (gtp_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : gtp_pkg::HEIGHT_RESET;

   logic [WV-1:0] eff_w_ff, eff_w_in;
   logic [HV-1:0] eff_h_ff, eff_h_in;
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          s1_valid_ff;
   logic [AW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic [PW-1:0] s1_pix_ff;
   logic          s1_fwd_ff;
   logic [2*PW-1:0] s1_fwd_data_ff;

   logic [PW-1:0] mid0_ff, mid1_ff, upper_ff, last_px_ff;

   logic [31:0]   w_req, h_req;
   logic [AW-1:0] c0;
   logic [RW-1:0] r0;
   logic          fwd_hit;
   logic [2*PW-1:0] ram_rd_data, line_data, wr_data;
   logic [PW-1:0] right_v, up_next;
   logic          interior, at_last;
   logic signed [gtp_pkg::GRAD_W:0] dx_sum, dy_sum;

   always_comb begin
      w_req = 32'(csr_wdata[gtp_pkg::WIDTH_REG_W-1:0]);
      h_req = 32'(csr_wdata[gtp_pkg::HEIGHT_REG_W-1:0]);
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_wen && csr_index == gtp_pkg::CFG_IMAGE_WIDTH) begin
         if (w_req < 32'(gtp_pkg::MIN_SIZE)) begin
            eff_w_in = WV'(gtp_pkg::MIN_SIZE);
         end else if (w_req > 32'(MAX_WIDTH)) begin
            eff_w_in = WV'(MAX_WIDTH);
         end else begin
            eff_w_in = WV'(w_req);
         end
      end
      if (csr_wen && csr_index == gtp_pkg::CFG_IMAGE_HEIGHT) begin
         if (h_req < 32'(gtp_pkg::MIN_SIZE)) begin
            eff_h_in = HV'(gtp_pkg::MIN_SIZE);
         end else if (h_req > 32'(MAX_HEIGHT)) begin
            eff_h_in = HV'(MAX_HEIGHT);
         end else begin
            eff_h_in = HV'(h_req);
         end
      end
   end

   always_comb begin
      c0 = req_frame_start ? '0 : col_ff;
      r0 = req_frame_start ? '0 : row_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (32'(c0) + 32'd1 >= 32'(eff_w_ff)) begin
            col_in = '0;
            row_in = (32'(r0) + 32'd1 >= 32'(eff_h_ff)) ? '0 : RW'(32'(r0) + 32'd1);
         end else begin
            col_in = AW'(32'(c0) + 32'd1);
            row_in = r0;
         end
      end
      fwd_hit = s1_valid_ff && (s1_col_ff == c0);
   end

   gtp_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (c0),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      line_data = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
      right_v   = line_data[PW-1:0];
      up_next   = line_data[2*PW-1:PW];
      wr_data   = {right_v, s1_pix_ff};

      dx_sum = $signed({2'b00, mid1_ff}) - $signed({2'b00, right_v}) + 10'sd1;
      dy_sum = $signed({2'b00, upper_ff}) - $signed({2'b00, last_px_ff}) + 10'sd1;

      interior = 32'(s1_row_ff) >= 32'd2 && 32'(s1_row_ff) + 32'd1 <= 32'(eff_h_ff)
              && 32'(s1_col_ff) >= 32'd2 && 32'(s1_col_ff) + 32'd1 <= 32'(eff_w_ff);
      at_last  = 32'(s1_row_ff) + 32'd1 == 32'(eff_h_ff)
              && 32'(s1_col_ff) + 32'd1 == 32'(eff_w_ff);

      grad.valid = s1_valid_ff && interior;
      grad.dx    = dx_sum[gtp_pkg::GRAD_W:1];
      grad.dy    = dy_sum[gtp_pkg::GRAD_W:1];
      grad.row   = gtp_pkg::ROW_W'(32'(s1_row_ff) - 32'd1);
      grad.col   = gtp_pkg::COL_W'(32'(s1_col_ff) - 32'd1);
      grad.last  = at_last;
      busy       = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff    <= WV'(W_RST);
         eff_h_ff    <= HV'(H_RST);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
         mid0_ff     <= '0;
         mid1_ff     <= '0;
         upper_ff    <= '0;
         last_px_ff  <= '0;
      end else begin
         eff_w_ff    <= eff_w_in;
         eff_h_ff    <= eff_h_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= req_accept;
         if (req_accept) begin
            s1_fwd_ff <= fwd_hit;
         end
         if (s1_valid_ff) begin
            mid0_ff    <= right_v;
            mid1_ff    <= mid0_ff;
            upper_ff   <= up_next;
            last_px_ff <= s1_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff      <= c0;
         s1_row_ff      <= r0;
         s1_pix_ff      <= req_pixel;
         s1_fwd_data_ff <= wr_data;
      end
   end

   `GTP_ASSERT_NEXT(a_accept_reaches_s1, clock, reset, req_accept, s1_valid_ff, "accepted word did not reach the line store stage")
   `GTP_ASSERT_NEXT(a_frame_start_origin, clock, reset, req_accept && req_frame_start, s1_col_ff == '0 && s1_row_ff == '0, "frame start did not restart at the origin")
   `GTP_ASSERT_IMPLY(a_forward_follows_write, clock, reset, s1_valid_ff && s1_fwd_ff, $past(s1_valid_ff), "line store forwarding without a preceding write")

endmodule

// File: hw/rtl/gtp_out_queue.sv
// ----------------------------------------------------------------------------
// Gradient tensor products: product stage and result queue
// Registers the gradients, forms the three products and buffers results
// in a small queue that decouples the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gradient_tensor_products_unit_defines.svh"

module gtp_out_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  gtp_pkg::grad_type               grad,
   output gtp_pkg::result_type             result,
   output logic                            result_valid,
   input  logic                            result_ready,
   output logic [gtp_pkg::QUEUE_CW-1:0]    used
);

   localparam int QD = gtp_pkg::QUEUE_DEPTH;
   localparam int QA = gtp_pkg::QUEUE_AW;
   localparam int QC = gtp_pkg::QUEUE_CW;

   gtp_pkg::grad_type   s2_ff;
   gtp_pkg::result_type entry_ff [QD];
   gtp_pkg::result_type product;
   logic [QA-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QC-1:0] count_ff, count_in;
   logic          push, pop;
   logic signed [gtp_pkg::PROD_W-1:0] xx_full, xy_full, yy_full;

   always_comb begin
      xx_full = s2_ff.dx * s2_ff.dx;
      xy_full = s2_ff.dx * s2_ff.dy;
      yy_full = s2_ff.dy * s2_ff.dy;
      product.xx   = xx_full[gtp_pkg::XX_W-1:0];
      product.xy   = xy_full[gtp_pkg::XY_W-1:0];
      product.yy   = yy_full[gtp_pkg::YY_W-1:0];
      product.row  = s2_ff.row;
      product.col  = s2_ff.col;
      product.last = s2_ff.last;

      push = s2_ff.valid;
      pop  = result_valid && result_ready;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QC'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QC'(1);
      end
      result_valid = count_ff != '0;
      result       = entry_ff[rd_ptr_ff];
      used         = count_ff + QC'(s2_ff.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s2_ff.valid <= grad.valid;
         count_ff    <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QA'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QA'(1);
         end
      end
      s2_ff.dx   <= grad.dx;
      s2_ff.dy   <= grad.dy;
      s2_ff.row  <= grad.row;
      s2_ff.col  <= grad.col;
      s2_ff.last <= grad.last;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= product;
      end
   end

   `GTP_ASSERT_IMPLY(a_no_overflow, clock, reset, push && !pop, count_ff < QC'(QD), "result queue overflow")
   `GTP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= QC'(QD), "result queue count out of range")
   `GTP_ASSERT_NEXT(a_push_not_empty, clock, reset, push && !pop, count_ff != '0, "pushed result missing from queue")

endmodule

// File: hw/rtl/gradient_tensor_products_unit.sv
// ----------------------------------------------------------------------------
// Gradient tensor products unit
// Central-difference gradients on a raster pixel stream and their
// structure tensor products dx*dx, dx*dy, dy*dy per interior pixel.
//
//   Channel  Direction  Contents
//   req_     in         pixel word, frame start in tuser
//   rsp_     out        products with center row and column, frame end in tlast
//   csr_     in         image width (index 0), image height (index 1)
//
// One word per cycle while req_tready is high; the word that completes a
// neighborhood passes the line store stage, product register and result
// queue. Both line stores share one RAM read and rewritten at the same
// column per word, with a forwarding path. req_tready drops only when
// the four-entry result queue has no room for words already in flight.
// Reset is synchronous; the uncleared line RAM may be read before written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_tensor_products_unit #(
   parameter int MAX_WIDTH  = gtp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gtp_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] pixel
   input  logic                              req_tuser,   // [0] frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [14:0] grad_xx, [30:15] grad_xy, [45:31] grad_yy, [57:46] center_row,
   // [68:58] center_col, [71:69] zero
   output logic [gtp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wen,
   input  logic [gtp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gtp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PAD_W = gtp_pkg::RSP_DATA_W - gtp_pkg::XX_W - gtp_pkg::XY_W
                        - gtp_pkg::YY_W - gtp_pkg::ROW_W - gtp_pkg::COL_W;

   logic                          req_accept;
   logic                          busy;
   gtp_pkg::grad_type             grad;
   gtp_pkg::result_type           result;
   logic [gtp_pkg::QUEUE_CW-1:0]  used;

   assign req_tready = 32'(used) + 32'(busy) < 32'(gtp_pkg::QUEUE_DEPTH);
   assign req_accept = req_tvalid && req_tready;

   gtp_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_accept      (req_accept),
      .req_pixel       (req_tdata[gtp_pkg::PIX_W-1:0]),
      .req_frame_start (req_tuser),
      .busy            (busy),
      .grad            (grad)
   );

   gtp_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .grad         (grad),
      .result       (result),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .used         (used)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, result.col, result.row, result.yy, result.xy,
                       result.xx};
   assign rsp_tlast = result.last;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Gradient tensor products unit testbench
// Streams raster pixel frames into the unit under random source and sink
// pauses, predicts the structure tensor products of every interior pixel,
// and checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int     MAX_W          = gtp_pkg::MAX_WIDTH_DEF;
   localparam int     MAX_H          = gtp_pkg::MAX_HEIGHT_DEF;
   localparam int     XY_LSB         = gtp_pkg::XX_W;
   localparam int     YY_LSB         = XY_LSB + gtp_pkg::XY_W;
   localparam int     ROW_LSB        = YY_LSB + gtp_pkg::YY_W;
   localparam int     COL_LSB        = ROW_LSB + gtp_pkg::ROW_W;
   localparam int     PAD_LSB        = COL_LSB + gtp_pkg::COL_W;
   localparam int     PAD_W          = gtp_pkg::RSP_DATA_W - PAD_LSB;
   localparam int     RANDOM_ITEMS   = 950;
   localparam int     WIDE_RUN       = 100;
   localparam int     TALL_ROWS      = 20;
   localparam int     DRAIN_CYCLES   = 10;
   localparam int     LONG_HOLD      = 300;
   localparam int     HOLD_AT_FIRST  = 40;
   localparam int     HOLD_AT_SECOND = 200;
   localparam int     MAX_REPORTS    = 50;
   localparam longint TIMEOUT_NS     = 40_000_000;
   localparam int unsigned IDLE_CHOICES [3] = '{0, 4, 12};
   localparam logic [7:0]  STEP_PATTERN [5] = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF};

   typedef struct {
      logic [7:0] pixel;
      logic       frame_start;
   } pixel_word_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [7:0]                          req_tdata = '0;
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [gtp_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   logic                                rsp_tlast;
   logic                                csr_wen = 1'b0;
   logic [gtp_pkg::CSR_INDEX_W-1:0]     csr_index = gtp_pkg::CFG_IMAGE_WIDTH;
   logic [gtp_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   pixel_word_type        pending_pixels [$];
   gtp_pkg::result_type   expected_products [$];
   int unsigned  mismatch_count = 0;
   int unsigned  idle_max = 0;
   int unsigned  send_gap = 0;
   int unsigned  rsp_stall = 0;
   int unsigned  taken_count = 0;

   // Predictor state: register copies, line stores, counters and taps.
   int unsigned  size_width = gtp_pkg::WIDTH_RESET;
   int unsigned  size_height = gtp_pkg::HEIGHT_RESET;
   logic [7:0]   line_above [MAX_W];
   logic [7:0]   line_above2 [MAX_W];
   int unsigned  row_pos = 0;
   int unsigned  col_pos = 0;
   logic [7:0]   prior_px = '0;
   logic [7:0]   left_taps [2] = '{8'h00, 8'h00};
   logic [7:0]   up_tap = '0;

   gradient_tensor_products_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned clamp_size(input int unsigned value, input int unsigned hi);
      if (value < gtp_pkg::MIN_SIZE) return gtp_pkg::MIN_SIZE;
      if (value > hi) return hi;
      return value;
   endfunction

   // Central difference halved, rounding toward positive infinity.
   function automatic int half_diff(input logic [7:0] a, input logic [7:0] b);
      int d;
      d = int'(a) - int'(b) + 1;
      return d >>> 1;
   endfunction

   function automatic logic [7:0] pick_pixel();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want, input gtp_pkg::result_type ref_word);
      if (got != want)
         report_mismatch($sformatf("%s at center (%0d,%0d): got 0x%0h, expected 0x%0h",
                                   name, ref_word.row, ref_word.col, got, want));
   endtask

   task automatic predict_products(input logic [7:0] pix, input logic frame_start);
      int unsigned w, h, r, c, pos;
      logic [7:0]  right_px, up_px;
      int          dx, dy, prod;
      gtp_pkg::result_type res;
      w = clamp_size(size_width, MAX_W);
      h = clamp_size(size_height, MAX_H);
      if (frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      right_px = line_above[c];
      up_px = line_above2[c];
      if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
         dx = half_diff(left_taps[1], right_px);
         dy = half_diff(up_tap, prior_px);
         prod = dx * dx;
         res.xx = prod[gtp_pkg::XX_W-1:0];
         prod = dx * dy;
         res.xy = prod[gtp_pkg::XY_W-1:0];
         prod = dy * dy;
         res.yy = prod[gtp_pkg::YY_W-1:0];
         pos = r - 1;
         res.row = pos[gtp_pkg::ROW_W-1:0];
         pos = c - 1;
         res.col = pos[gtp_pkg::COL_W-1:0];
         res.last = (r == h - 1) && (c == w - 1);
         expected_products.push_back(res);
      end
      line_above2[c] = right_px;
      line_above[c] = pix;
      left_taps[1] = left_taps[0];
      left_taps[0] = right_px;
      up_tap = up_px;
      prior_px = pix;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin : sender
      pixel_word_type word;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_pixels.size() != 0) begin
            word = pending_pixels.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= word.pixel;
            req_tuser <= word.frame_start;
            send_gap <= $urandom_range(0, idle_max);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // The sink may pause after each word; twice it holds long enough for the
   // unit's result queue to fill and back up into the pixel channel.
   always @(posedge clock) begin : receiver
      int unsigned pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
         taken_count <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         pause = $urandom_range(0, idle_max);
         if (taken_count == HOLD_AT_FIRST || taken_count == HOLD_AT_SECOND)
            pause = LONG_HOLD;
         taken_count <= taken_count + 1;
         rsp_tready <= (pause == 0);
         rsp_stall <= pause;
      end else if (!rsp_tready) begin
         if (rsp_stall > 1) rsp_stall <= rsp_stall - 1;
         else rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      gtp_pkg::result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) predict_products(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_products.size() == 0) begin
               report_mismatch($sformatf("result word with no prediction, center (%0d,%0d)",
                                         rsp_tdata[ROW_LSB +: gtp_pkg::ROW_W],
                                         rsp_tdata[COL_LSB +: gtp_pkg::COL_W]));
            end else begin
               want = expected_products.pop_front();
               check_field("grad_xx", rsp_tdata[0 +: gtp_pkg::XX_W], want.xx, want);
               check_field("grad_xy", rsp_tdata[XY_LSB +: gtp_pkg::XY_W], want.xy, want);
               check_field("grad_yy", rsp_tdata[YY_LSB +: gtp_pkg::YY_W], want.yy, want);
               check_field("center_row", rsp_tdata[ROW_LSB +: gtp_pkg::ROW_W], want.row,
                           want);
               check_field("center_col", rsp_tdata[COL_LSB +: gtp_pkg::COL_W], want.col,
                           want);
               check_field("frame_last", rsp_tlast, want.last, want);
               check_field("padding", rsp_tdata[PAD_LSB +: PAD_W], 0, want);
            end
         end
      end
   end

   task automatic write_sizes(input int unsigned width_val, input int unsigned height_val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= gtp_pkg::CFG_IMAGE_WIDTH;
      csr_wdata <= width_val[gtp_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= gtp_pkg::CFG_IMAGE_HEIGHT;
      csr_wdata <= height_val[gtp_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wen <= 1'b0;
      size_width = width_val & ((1 << gtp_pkg::WIDTH_REG_W) - 1);
      size_height = height_val & ((1 << gtp_pkg::HEIGHT_REG_W) - 1);
      @(negedge clock);
   endtask

   task automatic queue_run(input int unsigned count, input bit start);
      pixel_word_type word;
      for (int unsigned i = 0; i < count; i++) begin
         word.pixel = pick_pixel();
         word.frame_start = start && (i == 0);
         pending_pixels.push_back(word);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || expected_products.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random phases: whole frames with and without a frame start, and frames
   // cut short by the next frame start.
   task automatic queue_random_phases();
      int unsigned queued, wreg, hreg, area, pos, segments, kind, len;
      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       wreg = $urandom_range(0, 2);
            8:       wreg = $urandom_range(9, 24);
            default: wreg = $urandom_range(3, 8);
         endcase
         case ($urandom_range(0, 9))
            0:       hreg = $urandom_range(0, 2);
            9:       hreg = $urandom_range(8, 16);
            default: hreg = $urandom_range(3, 7);
         endcase
         write_sizes(wreg, hreg);
         idle_max = IDLE_CHOICES[$urandom_range(0, 2)];
         area = clamp_size(wreg, MAX_W) * clamp_size(hreg, MAX_H);
         pos = 1;
         segments = $urandom_range(1, 6);
         repeat (segments) begin
            kind = $urandom_range(0, 9);
            if (kind >= 8) begin
               len = $urandom_range(1, area - 1);
               queue_run(len, 1'b1);
               pos = len;
            end else begin
               len = area;
               queue_run(len, !(kind >= 6 && pos == 0));
               pos = 0;
            end
            queued += len;
         end
         wait_drained();
      end
   endtask

   initial begin
      pixel_word_type word;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Step pattern frame: gradients of +128 and -127 in both directions.
      write_sizes(5, 5);
      idle_max = 0;
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            word.pixel = STEP_PATTERN[c] ^ STEP_PATTERN[r];
            word.frame_start = (r == 0) && (c == 0);
            pending_pixels.push_back(word);
         end
      end
      wait_drained();

      // Widest setting; width and height both clamp.
      write_sizes(4095, 0);
      idle_max = 3;
      queue_run(WIDE_RUN, 1'b1);
      wait_drained();

      // Size changes in the middle of a frame, shrinking and then growing.
      write_sizes(9, 7);
      idle_max = 4;
      queue_run(40, 1'b1);
      wait_drained();
      write_sizes(5, 4);
      queue_run(50, 1'b0);
      wait_drained();
      write_sizes(9, 9);
      queue_run(60, 1'b0);
      wait_drained();

      // Tall frame at the narrowest width.
      write_sizes(1, MAX_H);
      idle_max = 3;
      queue_run(gtp_pkg::MIN_SIZE * TALL_ROWS, 1'b1);
      wait_drained();

      write_sizes(4, 8191);
      idle_max = 12;
      queue_run(30, 1'b1);
      wait_drained();

      queue_random_phases();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule
